>>> rtl/core/sic_pkg.sv
package sic_pkg;

  // revolutions measured by one calibration
  localparam int SPINS = 3;
  localparam int PHASES = 8;

  localparam int PHASE_W = $clog2(PHASES);

  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam logic [17:0] MAX18 = 18'h3FFFF;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  // reciprocal of SPINS for the end-of-calibration divide
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W = 22;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + SPINS - 1) / SPINS);

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_CAL   = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_ALIGN = 2'd3
  } kind_t;

  // half-step coil pattern, bit0 = coil A
  function automatic logic [3:0] coil_lookup(input logic [PHASE_W-1:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/sic_cal_div.sv
module sic_cal_div (
  input  logic [17:0] sum_steps,
  input  logic [17:0] sum_low_steps,
  output logic [15:0] rev_steps,
  output logic [15:0] align_steps
);

  localparam int PROD_W = 18 + sic_pkg::RECIP_W;
  localparam int QUO_W = PROD_W - sic_pkg::RECIP_SHIFT;

  logic [PROD_W-1:0] rev_prod;
  logic [PROD_W-1:0] low_prod;
  logic [QUO_W-1:0]  rev_quo;
  logic [QUO_W-1:0]  low_quo;
  logic [QUO_W-1:0]  align_quo;

  // divide by SPINS through the reciprocal; halve the low count afterwards
  assign rev_prod = PROD_W'(sum_steps) * PROD_W'(sic_pkg::RECIP);
  assign low_prod = PROD_W'(sum_low_steps) * PROD_W'(sic_pkg::RECIP);
  assign rev_quo = rev_prod[PROD_W-1:sic_pkg::RECIP_SHIFT];
  assign low_quo = low_prod[PROD_W-1:sic_pkg::RECIP_SHIFT];
  assign align_quo = low_quo >> 1;

  assign rev_steps = (rev_quo > QUO_W'(sic_pkg::MAX16)) ? sic_pkg::MAX16 : rev_quo[15:0];
  assign align_steps = (align_quo > QUO_W'(sic_pkg::MAX16)) ? sic_pkg::MAX16
                                                            : align_quo[15:0];

endmodule

>>> rtl/core/stepper_index_calibrator.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | kind, opto_level, count
// out_    | output    | out_valid/out_stall | coils, stepped, busy_res, job_done, rejected,
//         |           |                     | rev_steps, align_steps
//
// One word is accepted per cycle while in_stall is low; its result is presented on the next cycle.
// The job state updates at the accepting edge, so back-to-back words chain.
// in_stall is raised only while a result is held and out_stall is high.
// Reset is synchronous, active low, and returns the job engine to idle.
module stepper_index_calibrator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic        in_opto_level,
  input  logic [15:0] in_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_coils,
  output logic        out_stepped,
  output logic        out_busy_res,
  output logic        out_job_done,
  output logic        out_rejected,
  output logic [15:0] out_rev_steps,
  output logic [15:0] out_align_steps
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SEEK    = 3'd1,
    MODE_MEASURE = 3'd2,
    MODE_RUN     = 3'd3,
    MODE_ALIGN   = 3'd4
  } mode_t;

  localparam int PW = sic_pkg::PHASE_W;

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [3:0]    coil_r, coil_nxt;
  logic          prev_opto_r, prev_opto_nxt;
  logic [1:0]    spin_idx_r, spin_idx_nxt;
  logic [15:0]   spin_steps_r, spin_steps_nxt;
  logic [15:0]   spin_low_r, spin_low_nxt;
  logic [17:0]   sum_steps_r, sum_steps_nxt;
  logic [17:0]   sum_low_r, sum_low_nxt;
  logic [23:0]   steps_left_r, steps_left_nxt;
  logic [15:0]   rev_r, rev_nxt;
  logic [15:0]   align_r, align_nxt;

  logic          out_valid_r;
  logic [3:0]    out_coils_r;
  logic          out_stepped_r, out_busy_r, out_done_r, out_rej_r;
  logic [15:0]   out_rev_r, out_align_r;

  logic          accept;
  logic          falling;
  logic          stepped, done, rejected;
  logic [28:0]   run_total;
  logic [23:0]   job_total;
  logic [15:0]   spin_steps_inc, spin_low_inc;
  logic [18:0]   sum_steps_add, sum_low_add;
  logic [17:0]   sum_steps_sat, sum_low_sat;
  logic [15:0]   div_rev, div_align;
  sic_pkg::kind_t kind;

  assign kind = sic_pkg::kind_t'(in_kind);
  assign in_stall = out_valid_r & out_stall;
  assign accept = in_valid & ~in_stall;
  assign falling = prev_opto_r & ~in_opto_level;

  assign run_total = 29'(rev_r[15:3]) * 29'(in_count);

  // per-turn counts including this step, then the running sums
  assign spin_steps_inc = (spin_steps_r != sic_pkg::MAX16) ? spin_steps_r + 16'd1
                                                          : spin_steps_r;
  assign spin_low_inc = (!in_opto_level && spin_low_r != sic_pkg::MAX16) ? spin_low_r + 16'd1
                                                                        : spin_low_r;
  assign sum_steps_add = 19'(sum_steps_r) + 19'(spin_steps_inc);
  assign sum_low_add = 19'(sum_low_r) + 19'(spin_low_inc);
  assign sum_steps_sat = (sum_steps_add > 19'(sic_pkg::MAX18)) ? sic_pkg::MAX18
                                                               : sum_steps_add[17:0];
  assign sum_low_sat = (sum_low_add > 19'(sic_pkg::MAX18)) ? sic_pkg::MAX18
                                                           : sum_low_add[17:0];

  sic_cal_div u_div (
    .sum_steps     (sum_steps_sat),
    .sum_low_steps (sum_low_sat),
    .rev_steps     (div_rev),
    .align_steps   (div_align)
  );

  always_comb begin
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    coil_nxt       = coil_r;
    prev_opto_nxt  = prev_opto_r;
    spin_idx_nxt   = spin_idx_r;
    spin_steps_nxt = spin_steps_r;
    spin_low_nxt   = spin_low_r;
    sum_steps_nxt  = sum_steps_r;
    sum_low_nxt    = sum_low_r;
    steps_left_nxt = steps_left_r;
    rev_nxt        = rev_r;
    align_nxt      = align_r;
    stepped        = 1'b0;
    done           = 1'b0;
    rejected       = 1'b0;
    job_total      = 24'(in_count);

    if (kind == sic_pkg::KIND_RUN) begin
      job_total = (run_total > 29'(sic_pkg::MAX24)) ? sic_pkg::MAX24 : run_total[23:0];
    end

    if (kind != sic_pkg::KIND_TICK) begin
      if (mode_r != MODE_IDLE) begin
        rejected = 1'b1;
      end else if (kind == sic_pkg::KIND_CAL) begin
        mode_nxt       = MODE_SEEK;
        prev_opto_nxt  = in_opto_level;
        spin_idx_nxt   = 2'd0;
        spin_steps_nxt = 16'd0;
        spin_low_nxt   = 16'd0;
        sum_steps_nxt  = 18'd0;
        sum_low_nxt    = 18'd0;
      end else begin
        steps_left_nxt = job_total;
        if (job_total == 24'd0) begin
          done = 1'b1;
        end else begin
          mode_nxt = (kind == sic_pkg::KIND_RUN) ? MODE_RUN : MODE_ALIGN;
        end
      end
    end else if (mode_r != MODE_IDLE) begin
      coil_nxt  = sic_pkg::coil_lookup(phase_r);
      phase_nxt = phase_r + PW'(1);
      stepped   = 1'b1;
      case (mode_r)
        MODE_SEEK: begin
          if (falling) begin
            mode_nxt       = MODE_MEASURE;
            spin_idx_nxt   = 2'd0;
            spin_steps_nxt = 16'd0;
            spin_low_nxt   = 16'd0;
          end
          prev_opto_nxt = in_opto_level;
        end
        MODE_MEASURE: begin
          spin_steps_nxt = spin_steps_inc;
          spin_low_nxt   = spin_low_inc;
          if (falling) begin
            sum_steps_nxt  = sum_steps_sat;
            sum_low_nxt    = sum_low_sat;
            spin_steps_nxt = 16'd0;
            spin_low_nxt   = 16'd0;
            if (32'(spin_idx_r) + 32'd1 >= 32'(sic_pkg::SPINS)) begin
              rev_nxt      = div_rev;
              align_nxt    = div_align;
              spin_idx_nxt = 2'd0;
              mode_nxt     = MODE_IDLE;
              done         = 1'b1;
            end else begin
              spin_idx_nxt = spin_idx_r + 2'd1;
            end
          end
          prev_opto_nxt = in_opto_level;
        end
        MODE_RUN, MODE_ALIGN: begin
          if (steps_left_r != 24'd0) begin
            steps_left_nxt = steps_left_r - 24'd1;
          end
          if (steps_left_r <= 24'd1) begin
            mode_nxt = MODE_IDLE;
            done     = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      phase_r      <= '0;
      coil_r       <= 4'd0;
      prev_opto_r  <= 1'b0;
      spin_idx_r   <= 2'd0;
      spin_steps_r <= 16'd0;
      spin_low_r   <= 16'd0;
      sum_steps_r  <= 18'd0;
      sum_low_r    <= 18'd0;
      steps_left_r <= 24'd0;
      rev_r        <= 16'd0;
      align_r      <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        mode_r       <= mode_nxt;
        phase_r      <= phase_nxt;
        coil_r       <= coil_nxt;
        prev_opto_r  <= prev_opto_nxt;
        spin_idx_r   <= spin_idx_nxt;
        spin_steps_r <= spin_steps_nxt;
        spin_low_r   <= spin_low_nxt;
        sum_steps_r  <= sum_steps_nxt;
        sum_low_r    <= sum_low_nxt;
        steps_left_r <= steps_left_nxt;
        rev_r        <= rev_nxt;
        align_r      <= align_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word holds while stalled; load only on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      out_coils_r   <= coil_nxt;
      out_stepped_r <= stepped;
      out_busy_r    <= (mode_nxt != MODE_IDLE);
      out_done_r    <= done;
      out_rej_r     <= rejected;
      out_rev_r     <= rev_nxt;
      out_align_r   <= align_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coils       = out_coils_r;
  assign out_stepped     = out_stepped_r;
  assign out_busy_res    = out_busy_r;
  assign out_job_done    = out_done_r;
  assign out_rejected    = out_rej_r;
  assign out_rev_steps   = out_rev_r;
  assign out_align_steps = out_align_r;

  a_step_ends_or_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stepped && !out_busy_res) |-> out_job_done)
    else $error("step reported with job neither busy nor done");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> (!out_stepped && !out_job_done && out_busy_res))
    else $error("rejected command changed job progress");

  a_tick_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == sic_pkg::KIND_TICK && mode_r != MODE_IDLE)
      |=> (out_valid && out_stepped))
    else $error("tick on busy job did not step");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD = 5;
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int LONG_HOLD   = 64;
  localparam int RANDOM_WORDS = 1600;
  localparam int REPORT_CAP  = 200;

  // half-step coil sequence, phase i in bits [4i+3:4i]
  localparam logic [31:0] HALF_STEP = 32'h98C4_6231;

  typedef enum logic [2:0] {
    JOB_IDLE,
    JOB_SEEK,
    JOB_MEASURE,
    JOB_RUN,
    JOB_ALIGN
  } job_t;

  typedef struct packed {
    logic [3:0]  coils;
    logic        stepped;
    logic        busy;
    logic        done;
    logic        rejected;
    logic [15:0] rev;
    logic [15:0] align;
  } step_report_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic        in_opto_level;
  logic [15:0] in_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_coils;
  logic        out_stepped;
  logic        out_busy_res;
  logic        out_job_done;
  logic        out_rejected;
  logic [15:0] out_rev_steps;
  logic [15:0] out_align_steps;

  stepper_index_calibrator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_opto_level  (in_opto_level),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coils      (out_coils),
    .out_stepped    (out_stepped),
    .out_busy_res   (out_busy_res),
    .out_job_done   (out_job_done),
    .out_rejected   (out_rejected),
    .out_rev_steps  (out_rev_steps),
    .out_align_steps(out_align_steps)
  );

  always #HALF_PERIOD clk = ~clk;

  // motor and calibration state as the block should hold it
  job_t        job = JOB_IDLE;
  logic [2:0]  phase_q = '0;
  logic [3:0]  coil_q = '0;
  logic        prev_opto_q = 1'b0;
  logic [1:0]  spin_idx = '0;
  logic [15:0] spin_cnt = '0;
  logic [15:0] spin_low = '0;
  logic [17:0] sum_cnt = '0;
  logic [17:0] sum_low = '0;
  logic [23:0] steps_left = '0;
  logic [15:0] rev_q = '0;
  logic [15:0] align_q = '0;

  step_report_t step_reports[$];
  step_report_t want;
  int          mismatches = 0;
  int          words_sent = 0;
  bit          idle_on = 1'b0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  function automatic int unsigned sat_add(input int unsigned a, input int unsigned b,
                                          input int unsigned top);
    int unsigned s;
    s = a + b;
    return (s > top) ? top : s;
  endfunction

  // mostly back to back, now and then a short gap, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic sequence_step(input sic_pkg::kind_t k, input logic opto,
                               input logic [15:0] cnt);
    step_report_t r;
    logic         falling;
    int unsigned  total;
    int unsigned  quot;
    r = '0;
    if (k != sic_pkg::KIND_TICK) begin
      if (job != JOB_IDLE) begin
        r.rejected = 1'b1;
      end else if (k == sic_pkg::KIND_CAL) begin
        job = JOB_SEEK;
        prev_opto_q = opto;
        spin_idx = '0;
        spin_cnt = '0;
        spin_low = '0;
        sum_cnt = '0;
        sum_low = '0;
      end else begin
        total = (k == sic_pkg::KIND_RUN) ? (int'(rev_q) / 8) * int'(cnt) : int'(cnt);
        if (total > sic_pkg::MAX24) total = sic_pkg::MAX24;
        steps_left = total[23:0];
        if (steps_left == 0) r.done = 1'b1;
        else job = (k == sic_pkg::KIND_RUN) ? JOB_RUN : JOB_ALIGN;
      end
    end else if (job != JOB_IDLE) begin
      falling = prev_opto_q && !opto;
      coil_q = HALF_STEP[int'(phase_q) * 4 +: 4];
      phase_q = phase_q + 3'd1;
      r.stepped = 1'b1;
      case (job)
        JOB_SEEK: begin
          if (falling) begin
            job = JOB_MEASURE;
            spin_idx = '0;
            spin_cnt = '0;
            spin_low = '0;
          end
          prev_opto_q = opto;
        end
        JOB_MEASURE: begin
          spin_cnt = 16'(sat_add(spin_cnt, 1, sic_pkg::MAX16));
          if (!opto) spin_low = 16'(sat_add(spin_low, 1, sic_pkg::MAX16));
          if (falling) begin
            sum_cnt = 18'(sat_add(sum_cnt, spin_cnt, sic_pkg::MAX18));
            sum_low = 18'(sat_add(sum_low, spin_low, sic_pkg::MAX18));
            spin_cnt = '0;
            spin_low = '0;
            if (int'(spin_idx) + 1 >= sic_pkg::SPINS) begin
              quot = int'(sum_cnt) / sic_pkg::SPINS;
              rev_q = (quot > sic_pkg::MAX16) ? sic_pkg::MAX16 : quot[15:0];
              quot = int'(sum_low) / sic_pkg::SPINS / 2;
              align_q = (quot > sic_pkg::MAX16) ? sic_pkg::MAX16 : quot[15:0];
              spin_idx = '0;
              job = JOB_IDLE;
              r.done = 1'b1;
            end else begin
              spin_idx = spin_idx + 2'd1;
            end
          end
          prev_opto_q = opto;
        end
        default: begin
          if (steps_left > 0) steps_left = steps_left - 24'd1;
          if (steps_left == 0) begin
            job = JOB_IDLE;
            r.done = 1'b1;
          end
        end
      endcase
    end
    r.coils = coil_q;
    r.busy = (job != JOB_IDLE);
    r.rev = rev_q;
    r.align = align_q;
    step_reports.push_back(r);
  endtask

  // enter and leave on a falling edge; valid stays up across back-to-back words
  task automatic send_word(input sic_pkg::kind_t k, input logic opto, input logic [15:0] cnt);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_opto_level <= opto;
    in_count <= cnt;
    do @(posedge clk); while (in_stall);
    if (k != sic_pkg::KIND_TICK || job != JOB_IDLE) words_sent++;
    sequence_step(k, opto, cnt);
    @(negedge clk);
  endtask

  task automatic send_stray_command();
    send_word(sic_pkg::kind_t'($urandom_range(1, 3)), 1'($urandom), 16'($urandom));
  endtask

  // tick until the job ends, with the odd command thrown in while busy
  task automatic drive_job(input sic_pkg::kind_t k, input logic [15:0] cnt);
    send_word(k, 1'($urandom), cnt);
    while (job != JOB_IDLE) begin
      if ($urandom_range(0, 99) < 8) send_stray_command();
      else send_word(sic_pkg::KIND_TICK, 1'($urandom), 16'($urandom));
    end
  endtask

  // spin a disk of len steps whose index window is low_len steps wide
  task automatic run_calibration(input int len, input int low_len, input int noise_pct);
    int   pos;
    int   guard;
    logic lvl;
    pos = $urandom_range(0, len - 1);
    send_word(sic_pkg::KIND_CAL, (pos < low_len) ? 1'b0 : 1'b1, 16'($urandom));
    guard = 0;
    while (job != JOB_IDLE && guard < 10 * len + 64) begin
      if ($urandom_range(0, 99) < 8) begin
        send_stray_command();
      end else begin
        pos = (pos + 1) % len;
        lvl = (pos < low_len) ? 1'b0 : 1'b1;
        if ($urandom_range(0, 99) < noise_pct) lvl = ~lvl;
        send_word(sic_pkg::KIND_TICK, lvl, 16'($urandom));
      end
      guard++;
    end
  endtask

  task automatic test_idle_and_zero_length();
    send_word(sic_pkg::KIND_TICK, 1'b0, 16'h0000);
    send_word(sic_pkg::KIND_TICK, 1'b1, 16'hFFFF);
    // no calibration yet, so a run of any length is empty
    send_word(sic_pkg::KIND_RUN, 1'b1, 16'hFFFF);
    send_word(sic_pkg::KIND_ALIGN, 1'b0, 16'h0000);
  endtask

  task automatic test_align_and_reject();
    send_word(sic_pkg::KIND_ALIGN, 1'b1, 16'd3);
    send_word(sic_pkg::KIND_CAL, 1'b1, 16'hFFFF);
    send_word(sic_pkg::KIND_TICK, 1'b1, 16'h0000);
    send_word(sic_pkg::KIND_RUN, 1'b0, 16'h5555);
    send_word(sic_pkg::KIND_TICK, 1'b0, 16'hAAAA);
    send_word(sic_pkg::KIND_ALIGN, 1'b1, 16'h0001);
    send_word(sic_pkg::KIND_TICK, 1'b1, 16'hFFFF);
  endtask

  task automatic test_calibrate_small();
    logic [9:0] levels;
    // start low and seek a few steps with no edge, then three two-step turns
    levels = 10'b0010101010;
    send_word(sic_pkg::KIND_CAL, 1'b0, 16'h0000);
    for (int i = 9; i >= 0; i--) send_word(sic_pkg::KIND_TICK, levels[i], 16'($urandom));
  endtask

  task automatic test_random_jobs();
    int stop_at;
    int len;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(2, 40);
          run_calibration(len, $urandom_range(1, len - 1), ($urandom_range(0, 1) == 0) ? 0 : 5);
        end
        3, 4, 5: drive_job(sic_pkg::KIND_RUN,
                           (rev_q < 8) ? 16'($urandom) : 16'($urandom_range(0, 6)));
        6, 7: drive_job(sic_pkg::KIND_ALIGN, 16'($urandom_range(0, 40)));
        8: repeat (3) send_word(sic_pkg::KIND_TICK, 1'($urandom), 16'($urandom));
        default: begin
          len = $urandom_range(2, 12);
          run_calibration(len, $urandom_range(1, len - 1), 20);
        end
      endcase
    end
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    holds_asked++;
    drive_job(sic_pkg::KIND_ALIGN, 16'd40);
    idle_on = 1'b1;
  endtask

  // a long run that outlasts the test; check its start only
  task automatic test_run_saturation();
    send_word(sic_pkg::KIND_RUN, 1'b0, 16'hFFFF);
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_stray_command();
      else send_word(sic_pkg::KIND_TICK, 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic report_field(input string field, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (step_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected word, expected none, actual coils %0h", $time, out_coils);
      end else begin
        want = step_reports.pop_front();
        report_field("coils", want.coils, out_coils);
        report_field("stepped", want.stepped, out_stepped);
        report_field("busy_res", want.busy, out_busy_res);
        report_field("job_done", want.done, out_job_done);
        report_field("rejected", want.rejected, out_rejected);
        report_field("rev_steps", want.rev, out_rev_steps);
        report_field("align_steps", want.align, out_align_steps);
      end
    end
  end

  // receiver: random stalls, plus a long hold whenever one is asked for
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != holds_asked) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = sic_pkg::KIND_TICK;
    in_opto_level = 1'b0;
    in_count = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_on = 1'b1;

    test_idle_and_zero_length();
    test_align_and_reject();
    test_calibrate_small();
    test_random_jobs();
    test_output_backpressure();
    test_run_saturation();

    in_valid <= 1'b0;
    while (step_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sic_pkg.sv
rtl/core/sic_cal_div.sv
rtl/core/stepper_index_calibrator.sv
verif/tb_top.sv
